// File: rtl/tfb_pkg.sv
// Shared command and colour codes for the two-plane e-paper frame store.
package tfb_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] color_type;

   localparam cmd_type CMD_RECT = 2'd0;
   localparam cmd_type CMD_FULL = 2'd1;
   localparam cmd_type CMD_READ = 2'd2;

   localparam color_type COLOR_BLACK = 2'd0;
   localparam color_type COLOR_WHITE = 2'd1;
   localparam color_type COLOR_RED   = 2'd2;
   localparam color_type COLOR_BAD   = 2'd3;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;

endpackage

// File: rtl/tricolor_framebuffer_rect_fill.sv
// Two-plane 1bpp frame store with rectangle fill, screen fill and byte read.
//
// Usage: present a command on the req_ ports and raise start while busy is
// low; the transaction is taken at that edge. Exactly one result follows on
// the rsp_ ports, marked by rsp_valid for one cycle; the receiver cannot
// stall it. busy is low again in the cycle the result is shown, so the next
// command may be taken then.
// How each command reaches its result strobe after the accepting edge:
//   invalid colour, empty rectangle, out-of-range read, unused cmd: result registered at the accepting edge
//   byte read: one memory read, then one output register
//   screen fill: one byte of each plane per cycle
//   rectangle fill: a setup step, then each covered byte is a
//     read-modify-write streamed one per cycle through the plane memories
//     (read in one cycle, merged and written back in the next), then DRAIN
// Both planes sit in simple dual-port memories with registered reads; the
// write port sets the screen-fill rate at one byte per cycle.
// Reset clears the control state only; plane contents are undefined until
// a screen fill has written them.
module tricolor_framebuffer_rect_fill #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 296
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tfb_pkg::cmd_type   req_cmd,
   input  tfb_pkg::color_type req_color,
   input  logic [7:0]         req_x_start,
   input  logic [7:0]         req_x_end,
   input  logic [8:0]         req_y_start,
   input  logic [8:0]         req_y_end,
   input  logic [12:0]        req_byte_index,
   output logic               rsp_valid,
   output logic [7:0]         rsp_bw_byte,
   output logic [7:0]         rsp_red_byte,
   output logic               rsp_bad_color
);
   import tfb_pkg::*;

   localparam int PLANE_BYTES = PANEL_WIDTH * PANEL_HEIGHT / 8;
   localparam int ADDR_W = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);
   localparam logic [ADDR_W-1:0] ROW_BYTES = ADDR_W'(PANEL_WIDTH / 8);

   typedef enum logic [2:0] {
      IDLE, SETUP, RECT, DRAIN, FULL, READ
   } state_type;

   state_type           state_ff, state_in;
   color_type           color_ff, color_in;
   logic [7:0]          sx_ff, sx_in;
   logic [7:0]          xe_ff, xe_in;
   logic [8:0]          ye_ff, ye_in;
   logic [8:0]          y_ff, y_in;
   logic [4:0]          col_ff, col_in;
   logic [4:0]          col_first_ff, col_first_in;
   logic [4:0]          col_last_ff, col_last_in;
   logic [ADDR_W-1:0]   row_base_ff, row_base_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [7:0]          mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_bw_ff, rsp_bw_in;
   logic [7:0]          rsp_red_ff, rsp_red_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic [7:0]          bw_plane [PLANE_BYTES];
   logic [7:0]          red_plane [PLANE_BYTES];
   logic [7:0]          bw_rdata_ff, red_rdata_ff;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_bw, wr_red;

   logic [10:0]         xe_clip, ye_clip;
   logic [7:0]          xe_last;
   logic [31:0]         bidx_wide;
   logic [7:0]          col_mask;

   assign busy          = (state_ff != IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bw_byte   = rsp_bw_ff;
   assign rsp_red_byte  = rsp_red_ff;
   assign rsp_bad_color = rsp_bad_ff;

   // Pixel mask of the current byte column, MSB is the leftmost pixel.
   always_comb begin
      logic [7:0] xk;
      for (int k = 0; k < 8; k++) begin
         xk = {col_ff, 3'(k)};
         col_mask[7-k] = (xk >= sx_ff) && (xk < xe_ff);
      end
   end

   always_comb begin
      xe_clip = (11'(req_x_end) < 11'(PANEL_WIDTH)) ? 11'(req_x_end) : 11'(PANEL_WIDTH);
      ye_clip = (11'(req_y_end) < 11'(PANEL_HEIGHT)) ? 11'(req_y_end) : 11'(PANEL_HEIGHT);
      xe_last = 8'(xe_clip) - 8'd1;
      bidx_wide = 32'(req_byte_index);
   end

   // Write port: screen fill writes constants, rectangle fill merges read data.
   always_comb begin
      wr_en   = (state_ff == FULL) || wr_pend_ff;
      wr_addr = (state_ff == FULL) ? sweep_ff : wr_addr_ff;
      if (state_ff == FULL) begin
         wr_bw  = (color_ff == COLOR_WHITE) ? BYTE_ONES : BYTE_ZERO;
         wr_red = (color_ff == COLOR_RED) ? BYTE_ZERO : BYTE_ONES;
      end else begin
         case (color_ff)
            COLOR_BLACK: begin
               wr_bw  = bw_rdata_ff & ~mask_ff;
               wr_red = red_rdata_ff | mask_ff;
            end
            COLOR_WHITE: begin
               wr_bw  = bw_rdata_ff | mask_ff;
               wr_red = red_rdata_ff | mask_ff;
            end
            default: begin
               wr_bw  = bw_rdata_ff & ~mask_ff;
               wr_red = red_rdata_ff & ~mask_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      color_in     = color_ff;
      sx_in        = sx_ff;
      xe_in        = xe_ff;
      ye_in        = ye_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      row_base_in  = row_base_ff;
      sweep_in     = sweep_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_bw_in    = BYTE_ZERO;
      rsp_red_in   = BYTE_ZERO;
      rsp_bad_in   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = row_base_ff + ADDR_W'(col_ff);

      case (state_ff)
         IDLE: begin
            if (start) begin
               color_in = req_color;
               case (req_cmd)
                  CMD_RECT, CMD_FULL: begin
                     if (req_color == COLOR_BAD) begin
                        rsp_valid_in = 1'b1;
                        rsp_bad_in   = 1'b1;
                     end else if (req_cmd == CMD_FULL) begin
                        sweep_in = '0;
                        state_in = FULL;
                     end else if ((11'(req_x_start) >= xe_clip) ||
                                  (11'(req_y_start) >= ye_clip)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        sx_in        = req_x_start;
                        xe_in        = 8'(xe_clip);
                        ye_in        = 9'(ye_clip);
                        y_in         = req_y_start;
                        col_first_in = req_x_start[7:3];
                        col_last_in  = xe_last[7:3];
                        state_in     = SETUP;
                     end
                  end
                  CMD_READ: begin
                     if (bidx_wide < 32'(PLANE_BYTES)) begin
                        rd_en    = 1'b1;
                        rd_addr  = bidx_wide[ADDR_W-1:0];
                        state_in = READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         SETUP: begin
            row_base_in = ADDR_W'(ADDR_W'(y_ff) * ROW_BYTES);
            col_in      = col_first_ff;
            state_in    = RECT;
         end
         RECT: begin
            // Issue the read now; merge and write back next cycle.
            rd_en      = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = rd_addr;
            mask_in    = col_mask;
            if (col_ff == col_last_ff) begin
               col_in      = col_first_ff;
               y_in        = y_ff + 9'd1;
               row_base_in = row_base_ff + ROW_BYTES;
               if ((10'(y_ff) + 10'd1) == 10'(ye_ff)) begin
                  state_in = DRAIN;
               end
            end else begin
               col_in = col_ff + 5'd1;
            end
         end
         DRAIN: begin
            state_in     = IDLE;
            rsp_valid_in = 1'b1;
         end
         FULL: begin
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == LAST_ADDR) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         READ: begin
            state_in     = IDLE;
            rsp_valid_in = 1'b1;
            rsp_bw_in    = bw_rdata_ff;
            rsp_red_in   = red_rdata_ff;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      sx_ff        <= sx_in;
      xe_ff        <= xe_in;
      ye_ff        <= ye_in;
      y_ff         <= y_in;
      col_ff       <= col_in;
      col_first_ff <= col_first_in;
      col_last_ff  <= col_last_in;
      row_base_ff  <= row_base_in;
      sweep_ff     <= sweep_in;
      wr_addr_ff   <= wr_addr_in;
      mask_ff      <= mask_in;
      rsp_bw_ff    <= rsp_bw_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_bad_ff   <= rsp_bad_in;
      if (reset) begin
         state_ff     <= IDLE;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bw_rdata_ff  <= bw_plane[rd_addr];
         red_rdata_ff <= red_plane[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bw_plane[wr_addr]  <= wr_bw;
         red_plane[wr_addr] <= wr_red;
      end
   end

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("result shown while a command is still running");

   a_wr_pend_in_fill: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == RECT || state_ff == DRAIN))
      else $error("write-back pending outside a rectangle fill");

   a_bad_has_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_bad_ff && rsp_valid_ff |-> (rsp_bw_ff == BYTE_ZERO && rsp_red_ff == BYTE_ZERO))
      else $error("invalid-colour result carries plane data");

   a_drain_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN) |-> wr_pend_ff)
      else $error("rectangle fill finishing without its last write-back");

   a_read_then_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == READ) |=> rsp_valid_ff)
      else $error("byte read did not produce a result");

endmodule
